### design/mttts_pkg.sv
package mttts_pkg;

    localparam int NUM_CHANNELS     = 16;
    localparam int PRESS_COUNT_BITS = 8;
    localparam int CH_W             = 4;

    localparam int SR_W    = 18;
    localparam int TPQ_W   = 15;
    localparam int LEN_W   = 28;
    localparam int TEMPO_W = 24;
    localparam int SAMP_W  = 48;
    localparam int DUR_W   = 32;
    localparam int STEP_W  = 20;
    localparam int NOTE_W  = 7;
    localparam int FREQ_W  = 31;

    localparam int MUL_A_W = 46;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DEN_W   = 35;

    localparam logic [19:0]        US_PER_S      = 20'd1000000;
    localparam logic [TEMPO_W-1:0] TEMPO_DEFAULT = 24'd500000;
    localparam logic [SR_W-1:0]    SR_DEFAULT    = 18'd44100;
    localparam logic [TPQ_W-1:0]   TPQ_DEFAULT   = 15'd96;
    localparam logic [7:0]         META_TEMPO    = 8'h51;
    localparam logic [7:0]         META_STATUS   = 8'hFF;

    localparam logic [0:0] CFG_SAMPLE_RATE = 1'b0;
    localparam logic [0:0] CFG_TICKS_PER_Q = 1'b1;

    typedef enum logic [3:0] {
        PH_DELTA, PH_STATUS, PH_ON_KEY, PH_SKIP, PH_SYSEX_LEN,
        PH_META_TYPE, PH_META_LEN, PH_TEMPO_LEN, PH_TEMPO_DATA
    } t_phase;

    typedef enum logic [2:0] {
        J_IDLE, J_MUL1, J_MUL2, J_DIV, J_OUT
    } t_job;

    function automatic logic [FREQ_W-1:0] freq_top(input logic [3:0] s);
        logic [FREQ_W-1:0] f;
        case (s)
            4'd0:    f = 31'd1097337155;
            4'd1:    f = 31'd1162588218;
            4'd2:    f = 31'd1231719311;
            4'd3:    f = 31'd1304961152;
            4'd4:    f = 31'd1382558180;
            4'd5:    f = 31'd1464769368;
            4'd6:    f = 31'd1551869087;
            4'd7:    f = 31'd1644148025;
            4'd8:    f = 31'd1741914154;
            4'd9:    f = 31'd1845493760;
            4'd10:   f = 31'd1955232530;
            4'd11:   f = 31'd2071496706;
            default: f = '0;
        endcase
        return f;
    endfunction

    // Octave and semitone found by comparison against multiples of twelve.
    function automatic logic [FREQ_W-1:0] note_freq(input logic [NOTE_W-1:0] n);
        logic [3:0]        oct;
        logic [NOTE_W-1:0] semi;
        oct = '0;
        for (int o = 1; o <= 10; o++) begin
            if (n >= NOTE_W'(12 * o)) begin
                oct = 4'(o);
            end
        end
        semi = n - NOTE_W'(oct * 4'd12);
        return freq_top(semi[3:0]) >> (4'd10 - oct);
    endfunction

endpackage

### design/mttts_mul.sv
module mttts_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mttts_pkg::MUL_A_W-1:0] i_a,
    input  logic [mttts_pkg::MUL_B_W-1:0] i_b,
    output logic                          o_done,
    output logic [mttts_pkg::PROD_W-1:0]  o_p
);
    import mttts_pkg::*;

    logic [PROD_W-1:0]  r_acc;
    logic [PROD_W-1:0]  r_mcand;
    logic [MUL_B_W-1:0] r_mplier;
    logic [4:0]         r_cnt;
    logic               r_busy;
    logic               r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(MUL_B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // One multiplier bit per cycle: add the shifted multiplicand when it is set.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= PROD_W'(i_a);
            r_mplier <= i_b;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[MUL_B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

### design/mttts_div.sv
module mttts_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [mttts_pkg::PROD_W-1:0] i_num,
    input  logic [mttts_pkg::DEN_W-1:0]  i_den,
    output logic                         o_done,
    output logic [mttts_pkg::PROD_W-1:0] o_quo
);
    import mttts_pkg::*;

    logic [DEN_W-1:0]  r_rem;
    logic [PROD_W-1:0] r_quo;
    logic [DEN_W-1:0]  r_den;
    logic [6:0]        r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    assign trial = {r_rem, r_quo[PROD_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(PROD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Restoring division, one quotient bit per cycle; the dividend shifts out
    // of the quotient register as the quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quo <= {r_quo[PROD_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### design/midi_track_to_tone_segments.sv
// An event byte that closes a segment is answered after two bit-serial multiplies and a
// bit-serial division of the duration with the phase step divided alongside, then the hand-over.
// Other bytes are taken whenever no segment job runs; a segment byte holds the input off
// until the finished segment is loaded for output, longer while an untaken segment waits.
// Reset is synchronous and active low; it restores the default sample rate, ticks
// per quarter and tempo and clears all parser and channel state.
module midi_track_to_tone_segments (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [7:0]                           i_data_byte,
    input  logic                                 i_end_of_track,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [mttts_pkg::SAMP_W-1:0]         o_start_sample,
    output logic [mttts_pkg::DUR_W-1:0]          o_duration_samples,
    output logic                                 o_tone_on,
    output logic [mttts_pkg::NOTE_W-1:0]         o_note_number,
    output logic [mttts_pkg::STEP_W-1:0]         o_phase_step,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [0:0]                           i_cfg_index,
    input  logic [mttts_pkg::SR_W-1:0]           i_cfg_data
);
    import mttts_pkg::*;

    localparam logic [PRESS_COUNT_BITS-1:0] PRESS_CAP = '1;

    logic [SR_W-1:0]    r_sr;
    logic [TPQ_W-1:0]   r_tpq;
    logic [DEN_W-1:0]   r_tpq_den;

    t_phase             r_phase, n_phase;
    logic [LEN_W-1:0]   r_acc, n_acc;
    logic [LEN_W-1:0]   r_skip, n_skip;
    logic [1:0]         r_tcap, n_tcap;
    logic [TEMPO_W-1:0] r_tempo, n_tempo;
    logic [LEN_W-1:0]   r_pend, n_pend;
    logic               r_seen, n_seen;
    logic [PRESS_COUNT_BITS-1:0] r_presses [NUM_CHANNELS];
    logic [PRESS_COUNT_BITS-1:0] n_presses [NUM_CHANNELS];
    logic [NOTE_W-1:0]  r_note [NUM_CHANNELS];
    logic [NOTE_W-1:0]  n_note [NUM_CHANNELS];
    logic [SAMP_W-1:0]  r_samples;

    t_job               r_jst, n_jst;
    logic [SAMP_W-1:0]  r_j_start;
    logic               r_j_on;
    logic [NOTE_W-1:0]  r_j_note;
    logic [TEMPO_W-1:0] r_j_tempo;
    logic               r_j_clr;
    logic               r_out_valid;
    logic [SAMP_W-1:0]  r_o_start;
    logic [DUR_W-1:0]   r_o_dur;
    logic               r_o_on;
    logic [NOTE_W-1:0]  r_o_note;
    logic [STEP_W-1:0]  r_o_step;

    logic               in_fire;
    logic               emit;
    logic [LEN_W-1:0]   vl;
    logic [3:0]         kind;
    logic [CH_W-1:0]    ch;
    logic [CH_W-1:0]    key_ch;
    logic               sel_on;
    logic [NOTE_W-1:0]  sel_note;

    logic               mul_start;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               mul_done;
    logic [PROD_W-1:0]  mul_p;
    logic               dd_start;
    logic               dd_done;
    logic [PROD_W-1:0]  dd_quo;
    logic               pd_done;
    logic [PROD_W-1:0]  pd_quo;
    logic               load_out;
    logic [DUR_W-1:0]   dur;
    logic [STEP_W-1:0]  step;

    assign in_fire     = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_jst == J_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr  <= SR_DEFAULT;
            r_tpq <= TPQ_DEFAULT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SAMPLE_RATE: r_sr  <= i_cfg_data;
                CFG_TICKS_PER_Q: r_tpq <= i_cfg_data[TPQ_W-1:0];
                default:         r_sr  <= r_sr;
            endcase
        end
    end

    // Divisor of the duration: microseconds per second times ticks per quarter.
    always_ff @(posedge i_clk) begin
        r_tpq_den <= DEN_W'(US_PER_S * ((r_tpq == '0) ? TPQ_W'(1) : r_tpq));
    end

    // The lowest channel holding presses supplies the note.
    always_comb begin
        sel_on   = 1'b0;
        sel_note = '0;
        for (int c = NUM_CHANNELS - 1; c >= 0; c--) begin
            if (r_presses[c] != '0) begin
                sel_on   = 1'b1;
                sel_note = r_note[c];
            end
        end
    end

    assign vl     = {r_acc[LEN_W-8:0], i_data_byte[6:0]};
    assign kind   = i_data_byte[7:4];
    assign ch     = i_data_byte[CH_W-1:0];
    assign key_ch = r_acc[CH_W-1:0];

    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_skip    = r_skip;
        n_tcap    = r_tcap;
        n_tempo   = r_tempo;
        n_pend    = r_pend;
        n_seen    = r_seen;
        n_presses = r_presses;
        n_note    = r_note;
        emit      = 1'b0;
        if (in_fire) begin
            unique case (r_phase)
                PH_DELTA: begin
                    n_acc = vl;
                    if (!i_data_byte[7]) begin
                        n_pend  = vl;
                        n_acc   = '0;
                        n_phase = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    emit   = r_seen;
                    n_seen = 1'b1;
                    case (kind) inside
                        4'h8: begin
                            if (r_presses[ch] != '0) begin
                                n_presses[ch] = r_presses[ch] - PRESS_COUNT_BITS'(1);
                                if (r_presses[ch] == PRESS_COUNT_BITS'(1)) begin
                                    n_note[ch] = '0;
                                end
                            end
                            n_skip  = LEN_W'(2);
                            n_phase = PH_SKIP;
                        end
                        4'h9: begin
                            n_acc   = LEN_W'(ch);
                            n_phase = PH_ON_KEY;
                        end
                        4'hA, 4'hB, 4'hE: begin
                            n_skip  = LEN_W'(2);
                            n_phase = PH_SKIP;
                        end
                        4'hF: begin
                            n_acc   = '0;
                            n_phase = (i_data_byte == META_STATUS) ? PH_META_TYPE
                                                                   : PH_SYSEX_LEN;
                        end
                        default: begin
                            n_skip  = LEN_W'(1);
                            n_phase = PH_SKIP;
                        end
                    endcase
                end
                PH_ON_KEY: begin
                    n_acc = '0;
                    if (r_presses[key_ch] != PRESS_CAP) begin
                        n_presses[key_ch] = r_presses[key_ch] + PRESS_COUNT_BITS'(1);
                    end
                    if (i_data_byte[6:0] > r_note[key_ch]) begin
                        n_note[key_ch] = i_data_byte[6:0];
                    end
                    n_skip  = LEN_W'(1);
                    n_phase = PH_SKIP;
                end
                PH_SKIP: begin
                    n_skip = r_skip - LEN_W'(1);
                    if (n_skip == '0) begin
                        n_phase = PH_DELTA;
                    end
                end
                PH_SYSEX_LEN, PH_META_LEN: begin
                    n_acc = vl;
                    if (!i_data_byte[7]) begin
                        n_acc   = '0;
                        n_skip  = vl;
                        n_phase = (vl != '0) ? PH_SKIP : PH_DELTA;
                    end
                end
                PH_META_TYPE: begin
                    n_acc   = '0;
                    n_phase = (i_data_byte == META_TEMPO) ? PH_TEMPO_LEN : PH_META_LEN;
                end
                PH_TEMPO_LEN: begin
                    n_acc = vl;
                    if (!i_data_byte[7]) begin
                        n_acc  = '0;
                        n_skip = vl;
                        if (vl >= LEN_W'(3)) begin
                            n_tcap  = '0;
                            n_phase = PH_TEMPO_DATA;
                        end else begin
                            n_phase = (vl != '0) ? PH_SKIP : PH_DELTA;
                        end
                    end
                end
                PH_TEMPO_DATA: begin
                    n_acc  = {r_acc[LEN_W-9:0], i_data_byte};
                    n_tcap = r_tcap + 2'd1;
                    n_skip = r_skip - LEN_W'(1);
                    if (r_tcap == 2'd2) begin
                        n_tempo = n_acc[TEMPO_W-1:0];
                        n_acc   = '0;
                        n_tcap  = '0;
                        n_phase = (n_skip != '0) ? PH_SKIP : PH_DELTA;
                    end
                end
                default: n_phase = PH_DELTA;
            endcase
            if (i_end_of_track) begin
                n_phase = PH_DELTA;
                n_acc   = '0;
                n_skip  = '0;
                n_tcap  = '0;
                n_tempo = TEMPO_DEFAULT;
                n_pend  = '0;
                n_seen  = 1'b0;
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    n_presses[c] = '0;
                    n_note[c]    = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DELTA;
            r_acc   <= '0;
            r_skip  <= '0;
            r_tcap  <= '0;
            r_tempo <= TEMPO_DEFAULT;
            r_pend  <= '0;
            r_seen  <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_presses[c] <= '0;
                r_note[c]    <= '0;
            end
        end else begin
            r_phase   <= n_phase;
            r_acc     <= n_acc;
            r_skip    <= n_skip;
            r_tcap    <= n_tcap;
            r_tempo   <= n_tempo;
            r_pend    <= n_pend;
            r_seen    <= n_seen;
            r_presses <= n_presses;
            r_note    <= n_note;
        end
    end

    // Segment job: delta times sample rate, times tempo, then divided by the
    // tick divisor, while the phase step divides alongside.
    always_comb begin
        n_jst     = r_jst;
        mul_start = 1'b0;
        mul_a     = MUL_A_W'(r_pend);
        mul_b     = MUL_B_W'(r_sr);
        dd_start  = 1'b0;
        load_out  = 1'b0;
        unique case (r_jst)
            J_IDLE: begin
                if (emit) begin
                    mul_start = 1'b1;
                    n_jst     = J_MUL1;
                end
            end
            J_MUL1: begin
                mul_a = mul_p[MUL_A_W-1:0];
                mul_b = r_j_tempo;
                if (mul_done) begin
                    mul_start = 1'b1;
                    n_jst     = J_MUL2;
                end
            end
            J_MUL2: begin
                if (mul_done) begin
                    dd_start = 1'b1;
                    n_jst    = J_DIV;
                end
            end
            J_DIV: begin
                if (dd_done && pd_done) begin
                    n_jst = J_OUT;
                end
            end
            J_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_jst    = J_IDLE;
                end
            end
            default: n_jst = J_IDLE;
        endcase
    end

    mttts_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    mttts_div u_dur_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dd_start),
        .i_num   (mul_p),
        .i_den   (r_tpq_den),
        .o_done  (dd_done),
        .o_quo   (dd_quo)
    );

    mttts_div u_step_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dd_start),
        .i_num   (PROD_W'(note_freq(r_j_note))),
        .i_den   (DEN_W'(r_sr)),
        .o_done  (pd_done),
        .o_quo   (pd_quo)
    );

    assign dur = (dd_quo[PROD_W-1:DUR_W] != '0) ? '1 : dd_quo[DUR_W-1:0];

    always_comb begin
        step = '0;
        if (r_j_on && r_sr != '0) begin
            step = (pd_quo[PROD_W-1:STEP_W] != '0) ? '1 : pd_quo[STEP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jst       <= J_IDLE;
            r_out_valid <= 1'b0;
            r_samples   <= '0;
        end else begin
            r_jst <= n_jst;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_fire && i_end_of_track) begin
                r_samples <= '0;
            end else if (load_out && !r_j_clr) begin
                r_samples <= r_samples + SAMP_W'(dur);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_j_start <= r_samples;
            r_j_on    <= sel_on;
            r_j_note  <= sel_note;
            r_j_tempo <= r_tempo;
            r_j_clr   <= i_end_of_track;
        end
        if (load_out) begin
            r_o_start <= r_j_start;
            r_o_dur   <= dur;
            r_o_on    <= r_j_on;
            r_o_note  <= r_j_note;
            r_o_step  <= step;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_start_sample     = r_o_start;
    assign o_duration_samples = r_o_dur;
    assign o_tone_on          = r_o_on;
    assign o_note_number      = r_o_note;
    assign o_phase_step       = r_o_step;

endmodule

### design/mttts_checker.sv
module mttts_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [mttts_pkg::SAMP_W-1:0] o_start_sample,
    input logic                         o_tone_on,
    input logic [mttts_pkg::NOTE_W-1:0] o_note_number,
    input logic [mttts_pkg::STEP_W-1:0] o_phase_step
);
    import mttts_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_start_sample))
        else $error("stalled segment changed");

    a_silence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_tone_on |-> o_note_number == '0 && o_phase_step == '0)
        else $error("silent segment carries a note");

    a_busy_before_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("segment appeared while input was open");

endmodule

bind midi_track_to_tone_segments mttts_checker u_mttts_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_start_sample (o_start_sample),
    .o_tone_on      (o_tone_on),
    .o_note_number  (o_note_number),
    .o_phase_step   (o_phase_step)
);

### tb/sv/midi_track_to_tone_segments_tb.sv
module midi_track_to_tone_segments_tb;
    import mttts_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       eot;
    } t_track_byte;

    typedef struct packed {
        logic [SAMP_W-1:0] start;
        logic [DUR_W-1:0]  dur;
        logic              on;
        logic [NOTE_W-1:0] note;
        logic [STEP_W-1:0] step;
    } t_tone_seg;

    // Q17 frequencies of the top octave, semitone by semitone from C.
    localparam logic [31:0] TONE_TOP [12] = '{
        32'd1097337155, 32'd1162588218, 32'd1231719311, 32'd1304961152,
        32'd1382558180, 32'd1464769368, 32'd1551869087, 32'd1644148025,
        32'd1741914154, 32'd1845493760, 32'd1955232530, 32'd2071496706
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [7:0]        i_data_byte = '0;
    logic              i_end_of_track = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [SAMP_W-1:0] o_start_sample;
    logic [DUR_W-1:0]  o_duration_samples;
    logic              o_tone_on;
    logic [NOTE_W-1:0] o_note_number;
    logic [STEP_W-1:0] o_phase_step;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [0:0]        i_cfg_index = '0;
    logic [SR_W-1:0]   i_cfg_data = '0;

    midi_track_to_tone_segments u_top (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predictor state
    logic [SR_W-1:0]   rate_hz = SR_DEFAULT;
    logic [TPQ_W-1:0]  tpq = TPQ_DEFAULT;
    t_phase            parse_at = PH_DELTA;
    logic [LEN_W-1:0]  acc = '0;
    logic [LEN_W-1:0]  skip_left = '0;
    logic [1:0]        tcap = '0;
    logic [TEMPO_W-1:0] tempo = TEMPO_DEFAULT;
    logic [LEN_W-1:0]  delta_pend = '0;
    logic              started = 1'b0;
    logic [PRESS_COUNT_BITS-1:0] presses [NUM_CHANNELS];
    logic [NOTE_W-1:0] held [NUM_CHANNELS];
    logic [SAMP_W-1:0] sample_pos = '0;

    t_track_byte byte_q [$];
    t_tone_seg   segment_q [$];
    int          bytes_taken = 0;
    int          segs_seen = 0;
    int          tones_seen = 0;
    int          mismatches = 0;
    bit          calm = 1'b0;

    task automatic clear_track();
        parse_at = PH_DELTA;
        acc = '0;
        skip_left = '0;
        tcap = '0;
        tempo = TEMPO_DEFAULT;
        delta_pend = '0;
        started = 1'b0;
        sample_pos = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            presses[c] = '0;
            held[c] = '0;
        end
    endtask

    function automatic logic [DUR_W-1:0] seg_duration(input logic [LEN_W-1:0] dl);
        longint unsigned den, num, q, r, tot;
        den = 64'd1000000 * ((tpq == 0) ? 64'd1 : 64'(tpq));
        num = 64'(dl) * 64'(rate_hz);
        if (tempo == 0) return '0;
        q = num / den;
        r = num % den;
        if (q > 64'hFFFF_FFFF) return '1;
        tot = q * 64'(tempo) + (r * 64'(tempo)) / den;
        return (tot > 64'hFFFF_FFFF) ? '1 : tot[31:0];
    endfunction

    task automatic close_segment();
        t_tone_seg s;
        longint unsigned f, p;
        s = '0;
        s.start = sample_pos;
        s.dur = seg_duration(delta_pend);
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (presses[c] != 0 && !s.on) begin
                s.on = 1'b1;
                s.note = held[c];
            end
        end
        if (s.on && rate_hz != 0) begin
            f = 64'(TONE_TOP[s.note % 12]) >> (10 - s.note / 12);
            p = f / 64'(rate_hz);
            s.step = (p > 64'hFFFFF) ? '1 : p[STEP_W-1:0];
        end
        segment_q.push_back(s);
        sample_pos = sample_pos + SAMP_W'(s.dur);
    endtask

    task automatic skip_then(input logic [LEN_W-1:0] n);
        skip_left = n;
        parse_at = (n != 0) ? PH_SKIP : PH_DELTA;
    endtask

    function automatic bit varlen_in(input logic [7:0] b);
        acc = {acc[LEN_W-8:0], b[6:0]};
        return !b[7];
    endfunction

    task automatic take_status(input logic [7:0] ev);
        logic [3:0] ch;
        ch = ev[3:0];
        case (ev[7:4])
            4'h8: begin
                if (presses[ch] != 0) begin
                    presses[ch] = presses[ch] - 1'b1;
                    if (presses[ch] == 0) held[ch] = '0;
                end
                skip_then(2);
            end
            4'h9: begin
                acc = LEN_W'(ch);
                parse_at = PH_ON_KEY;
            end
            4'hA, 4'hB, 4'hE: skip_then(2);
            4'hC, 4'hD: skip_then(1);
            4'hF: begin
                acc = '0;
                parse_at = (ev == META_STATUS) ? PH_META_TYPE : PH_SYSEX_LEN;
            end
            default: skip_then(1);
        endcase
    endtask

    task automatic track_step(input logic [7:0] b, input logic last);
        logic [3:0] ch;
        case (parse_at)
            PH_DELTA: begin
                if (varlen_in(b)) begin
                    delta_pend = acc;
                    acc = '0;
                    parse_at = PH_STATUS;
                end
            end
            PH_STATUS: begin
                if (started) close_segment();
                started = 1'b1;
                take_status(b);
            end
            PH_ON_KEY: begin
                ch = acc[3:0];
                acc = '0;
                if (presses[ch] != '1) presses[ch] = presses[ch] + 1'b1;
                if (b[6:0] > held[ch]) held[ch] = b[6:0];
                skip_then(1);
            end
            PH_SKIP: begin
                skip_left = skip_left - 1'b1;
                if (skip_left == 0) parse_at = PH_DELTA;
            end
            PH_SYSEX_LEN, PH_META_LEN: begin
                if (varlen_in(b)) begin
                    skip_then(acc);
                    acc = '0;
                end
            end
            PH_META_TYPE: begin
                acc = '0;
                parse_at = (b == META_TEMPO) ? PH_TEMPO_LEN : PH_META_LEN;
            end
            PH_TEMPO_LEN: begin
                if (varlen_in(b)) begin
                    if (acc >= 3) begin
                        skip_left = acc;
                        tcap = '0;
                        parse_at = PH_TEMPO_DATA;
                    end else begin
                        skip_then(acc);
                    end
                    acc = '0;
                end
            end
            PH_TEMPO_DATA: begin
                acc = {acc[LEN_W-9:0], b};
                tcap = tcap + 1'b1;
                skip_left = skip_left - 1'b1;
                if (tcap == 2'd3) begin
                    tempo = acc[TEMPO_W-1:0];
                    acc = '0;
                    tcap = '0;
                    parse_at = (skip_left != 0) ? PH_SKIP : PH_DELTA;
                end
            end
            default: parse_at = PH_DELTA;
        endcase
        if (last) clear_track();
    endtask

    // Request driver
    int in_gap = 0;
    always @(posedge i_clk) begin
        t_track_byte nxt;
        bit          holding;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            holding = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                track_step(i_data_byte, i_end_of_track);
                bytes_taken++;
                holding = 1'b0;
            end
            if (!holding) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (byte_q.size() > 0) begin
                    nxt = byte_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_data_byte <= nxt.data;
                    i_end_of_track <= nxt.eot;
                    if (!calm && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 8);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Segment monitor with random back-pressure
    int out_stall = 0;
    always @(posedge i_clk) begin
        t_tone_seg want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (segment_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected segment start=%0d dur=%0d", o_start_sample,
                             o_duration_samples);
            end else begin
                want = segment_q.pop_front();
                segs_seen++;
                if (o_tone_on) tones_seen++;
                if (o_start_sample !== want.start || o_duration_samples !== want.dur ||
                    o_tone_on !== want.on || o_note_number !== want.note ||
                    o_phase_step !== want.step) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("segment mismatch: exp start=%0d dur=%0d on=%0b note=%0d step=%0d",
                                 want.start, want.dur, want.on, want.note, want.step);
                        $display("                  got start=%0d dur=%0d on=%0b note=%0d step=%0d",
                                 o_start_sample, o_duration_samples, o_tone_on,
                                 o_note_number, o_phase_step);
                    end
                end
            end
        end
        if (out_stall > 0) begin
            out_stall--;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            out_stall = $urandom_range(0, 7);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic put(input logic [7:0] b, input logic e = 1'b0);
        byte_q.push_back('{data: b, eot: e});
    endtask

    task automatic put_varlen(input logic [LEN_W-1:0] v);
        if (v >= 28'h200000) put({1'b1, v[27:21]});
        if (v >= 28'h4000) put({1'b1, v[20:14]});
        if (v >= 28'h80) put({1'b1, v[13:7]});
        put({1'b0, v[6:0]});
    endtask

    task automatic put_delta();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) put_varlen($urandom_range(0, 127));
        else if (pick < 9) put_varlen($urandom_range(128, 16383));
        else begin
            // A run of continuation bytes before the last byte; in the longest runs the top bits fall away.
            repeat ($urandom_range(1, 5)) put(8'h80 | 8'($urandom_range(0, 127)));
            put(8'($urandom_range(0, 127)));
        end
    endtask

    task automatic put_event(input int focus_ch);
        int  kind, n;
        logic [3:0] ch;
        ch = (focus_ch >= 0) ? 4'(focus_ch) : 4'($urandom_range(0, 15));
        put_delta();
        kind = $urandom_range(0, 19);
        if (kind < 7) begin
            put({4'h9, ch}); put(8'($urandom)); put(8'($urandom));
        end else if (kind < 12) begin
            put({4'h8, ch}); put(8'($urandom)); put(8'($urandom));
        end else if (kind < 14) begin
            put({4'($urandom_range(10, 14)), ch}); put(8'($urandom));
            if ($urandom_range(0, 1) == 0) put(8'($urandom));
        end else if (kind < 16) begin
            put(META_STATUS); put(META_TEMPO);
            n = $urandom_range(0, 5);
            put(8'(n));
            repeat (n) put(8'($urandom));
        end else if (kind < 17) begin
            put(META_STATUS); put(8'($urandom));
            n = $urandom_range(0, 4); put_varlen(n);
            repeat (n) put(8'($urandom));
        end else if (kind < 18) begin
            put(8'($urandom_range(240, 254)));
            n = $urandom_range(0, 6); put_varlen(n);
            repeat (n) put(8'($urandom));
        end else if (kind < 19) begin
            // Running-status style data byte in the status slot.
            put(8'($urandom_range(0, 127))); put(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 4)) put(8'($urandom), $urandom_range(0, 15) == 0);
        end
        if ($urandom_range(0, 39) == 0) put(8'($urandom), 1'b1);
    endtask

    task automatic drain(input int settle);
        while (byte_q.size() > 0 || i_in_valid || segment_q.size() > 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [0:0] idx, input logic [SR_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_SAMPLE_RATE) rate_hz = val;
        else tpq = val[TPQ_W-1:0];
    endtask

    task automatic random_phase(input int count);
        int start;
        start = byte_q.size();
        while (byte_q.size() - start < count) put_event(-1);
        put(8'h00, 1'b1);
    endtask

    initial begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            presses[c] = '0;
            held[c] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed track under the default settings.
        put(8'h00); put(8'h90); put(8'hBC); put(8'h40);
        put(8'h60); put(8'h9F); put(8'h00); put(8'h7F);
        put(8'h81); put(8'h00); put(8'h80); put(8'h3C); put(8'h00);
        put(8'h00); put(8'h85); put(8'h01); put(8'h00);
        put(8'h10); put(8'hFF); put(8'h51); put(8'h03);
        put(8'hFF); put(8'hFF); put(8'hFF);
        put(8'hFF); put(8'hFF); put(8'hFF); put(8'h7F); put(8'h45); put(8'h00);
        put(8'h00); put(8'hFF); put(8'h51); put(8'h02); put(8'h01); put(8'h02);
        put(8'h00); put(8'hFF); put(8'h51); put(8'h04);
        put(8'h00); put(8'h00); put(8'h00); put(8'h33);
        put(8'h05); put(8'hF0); put(8'h02); put(8'hAA); put(8'hBB);
        put(8'h05); put(8'hA0); put(8'h01); put(8'h02);
        put(8'h05); put(8'hC3); put(8'h01);
        put(8'h05); put(8'hF7); put(8'hFF); put(8'hFF); put(8'h7F); put(8'h00);
        put(8'h00, 1'b1);
        drain(150);

        cfg_write(CFG_SAMPLE_RATE, 18'd8000);
        cfg_write(CFG_TICKS_PER_Q, 18'd1);
        random_phase(70);
        // Press count saturation on a single channel.
        repeat (256) begin
            put(8'h00); put(8'h93); put(8'($urandom)); put(8'h40);
        end
        put(8'h00); put(8'h83); put(8'h00); put(8'h00);
        put(8'h00); put(8'hB0); put(8'h00); put(8'h00, 1'b1);
        drain(150);

        cfg_write(CFG_SAMPLE_RATE, 18'd192000);
        cfg_write(CFG_TICKS_PER_Q, 18'd32767);
        random_phase(70);
        drain(150);

        cfg_write(CFG_SAMPLE_RATE, 18'h3FFFF);
        cfg_write(CFG_TICKS_PER_Q, 18'd1);
        random_phase(70);
        drain(150);

        cfg_write(CFG_SAMPLE_RATE, 18'd0);
        cfg_write(CFG_TICKS_PER_Q, 18'd0);
        random_phase(70);
        drain(150);

        cfg_write(CFG_SAMPLE_RATE, 18'($urandom_range(8000, 192000)));
        cfg_write(CFG_TICKS_PER_Q, 18'($urandom_range(1, 32767)));
        random_phase(70);
        drain(150);

        calm = 1'b1;
        cfg_write(CFG_SAMPLE_RATE, 18'd48000);
        cfg_write(CFG_TICKS_PER_Q, 18'd480);
        random_phase(70);
        drain(150);

        $display("Covered %0d track bytes and %0d segments (%0d sounding) over seven settings.",
                 bytes_taken, segs_seen, tones_seen);
        if (mismatches == 0 && segment_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches, %0d segments missing", mismatches, segment_q.size());
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Timed out with %0d bytes queued", byte_q.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
